[design/imr_pkg.sv]
`default_nettype none
package imr_pkg;

  typedef enum logic [14:0] {
    PH_IDLE     = 15'b000000000000001,
    PH_START_A  = 15'b000000000000010,
    PH_START_B  = 15'b000000000000100,
    PH_TX_LO    = 15'b000000000001000,
    PH_TX_HI    = 15'b000000000010000,
    PH_ACKIN_LO = 15'b000000000100000,
    PH_ACKIN_HI = 15'b000000001000000,
    PH_RX_LO    = 15'b000000010000000,
    PH_RX_HI    = 15'b000000100000000,
    PH_MACK_LO  = 15'b000001000000000,
    PH_MACK_HI  = 15'b000010000000000,
    PH_RESTART  = 15'b000100000000000,
    PH_STOP_A   = 15'b001000000000000,
    PH_STOP_B   = 15'b010000000000000,
    PH_STOP_C   = 15'b100000000000000
  } phase_t;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_BURST = 2'd3;

  localparam logic [7:0]  BURST_START_REG = 8'h03;
  localparam logic [15:0] AXIS_OVERFLOW   = 16'hF000;
  localparam logic [15:0] AXIS_OFFSET     = 16'd2048;

  localparam logic CFG_HALF_BIT = 1'b0;
  localparam logic CFG_DEV_ADDR = 1'b1;

  // one tick as it travels from the front to the engine
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_sel;
    logic [7:0] wr_byte;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic        nack;
    logic [7:0]  read_data;
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [15:0] z_value;
  } res_t;

  function automatic logic [15:0] convert_axis(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] raw;
    raw = {hi, lo};
    if (raw == AXIS_OVERFLOW) return 16'd0;
    return raw + AXIS_OFFSET;
  endfunction

endpackage
`default_nettype wire

[design/i2c_magnetometer_reader.sv]
// i2c_magnetometer_reader: register read/write and axis burst master for an i2c slave
//
// input channel (in_push / in_full): one transfer per timing tick, carrying the
// command code, register address, write data and the sampled sda level.
// result channel (out_empty / out_pop): exactly one result per tick with the
// line drive, busy/done/nack flags, the last read byte and the three axes.
// configuration over the cfg_ apb port: half_bit_ticks at 0x0, device_address at 0x4.
//
// a tick enters a two-entry front queue, the engine takes one tick per cycle
// whenever the two-entry result queue has room, so sustained throughput is one
// tick per clock; a tick is registered in the front queue, and its result in the
// result queue, before that result reaches the out_ ports.
// a stalled receiver fills the result queue, then the front queue, then
// in_full rises; no tick is dropped.
// reset clears both queues, idles the bus state machine and loads the
// register defaults (7 ticks per half bit, address 30).
`default_nettype none
module i2c_magnetometer_reader (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_reg_sel,
  input  wire logic [7:0]  in_wr_byte,
  input  wire logic        in_sda_in,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_scl_out,
  output logic             out_sda_out,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic             out_nack,
  output logic [7:0]       out_read_data,
  output logic [15:0]      out_x_value,
  output logic [15:0]      out_y_value,
  output logic [15:0]      out_z_value,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int TW = $bits(imr_pkg::tick_t);
  localparam int RW = $bits(imr_pkg::res_t);

  logic [7:0] hbt_r;
  logic [6:0] dev_r;
  logic       cfg_idx;
  logic       cfg_wr;

  // register index is the word address
  assign cfg_idx    = cfg_paddr[2] ? imr_pkg::CFG_DEV_ADDR : imr_pkg::CFG_HALF_BIT;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbt_r <= 8'd7;
      dev_r <= 7'd30;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        imr_pkg::CFG_HALF_BIT: hbt_r <= cfg_pwdata[7:0];
        imr_pkg::CFG_DEV_ADDR: dev_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      imr_pkg::CFG_HALF_BIT: cfg_prdata = {24'd0, hbt_r};
      imr_pkg::CFG_DEV_ADDR: cfg_prdata = {25'd0, dev_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // front queue
  imr_pkg::tick_t in_tk, q_tk;
  logic [TW-1:0]  q_bits;
  logic           q_empty, tk_take;
  assign in_tk = '{func: in_func, reg_sel: in_reg_sel, wr_byte: in_wr_byte,
                   sda_in: in_sda_in};
  assign q_tk  = imr_pkg::tick_t'(q_bits);

  imr_fifo #(.WIDTH(TW)) u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .din(in_tk), .full(in_full),
    .pop(tk_take), .dout(q_bits), .empty(q_empty)
  );

  // bus engine
  imr_pkg::res_t res, out_res;
  logic          res_push, res_full;
  logic [RW-1:0] out_bits;

  imr_engine u_engine (
    .clk(clk), .rst_n(rst_n), .tk_valid(!q_empty), .tk(q_tk), .tk_take(tk_take),
    .res_full(res_full), .res_push(res_push), .res(res),
    .half_bit_ticks(hbt_r), .device_address(dev_r)
  );

  // result queue
  imr_fifo #(.WIDTH(RW)) u_back (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(res), .full(res_full),
    .pop(out_pop), .dout(out_bits), .empty(out_empty)
  );
  assign out_res       = imr_pkg::res_t'(out_bits);
  assign out_scl_out   = out_res.scl_out;
  assign out_sda_out   = out_res.sda_out;
  assign out_busy_res  = out_res.busy_res;
  assign out_done_res  = out_res.done_res;
  assign out_nack      = out_res.nack;
  assign out_read_data = out_res.read_data;
  assign out_x_value   = out_res.x_value;
  assign out_y_value   = out_res.y_value;
  assign out_z_value   = out_res.z_value;

  a_take_push: assert property (@(posedge clk) disable iff (!rst_n)
    tk_take |-> res_push && !res_full) else $error("tick taken with no result");
  a_cfg_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready) else $error("pready dropped");
  a_cfg_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_paddr == 3'd0 |=> hbt_r == $past(cfg_pwdata[7:0]))
    else $error("timing register not written");
endmodule
`default_nettype wire

[design/imr_fifo.sv]
`default_nettype none
module imr_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);
  // two-entry queue, full only when both slots hold data
  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

  property p_no_wrap;
    @(posedge clk) disable iff (!rst_n) full && !do_pop |=> full;
  endproperty
  a_no_wrap: assert property (p_no_wrap) else $error("queue lost an entry");
  a_cnt_ok: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count did not rise");
endmodule
`default_nettype wire

[design/imr_engine.sv]
`default_nettype none
module imr_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tk_valid,
  input  wire imr_pkg::tick_t tk,
  output logic               tk_take,
  input  wire logic          res_full,
  output logic               res_push,
  output imr_pkg::res_t      res,
  input  wire logic [7:0]    half_bit_ticks,
  input  wire logic [6:0]    device_address
);
  imr_pkg::phase_t phase_r, phase_nxt, ph;
  logic [7:0]  tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [7:0]  lreg_r, lreg_nxt, ldat_r, ldat_nxt;
  logic        nack_r, nack_nxt;
  logic [7:0]  rbyte_r, rbyte_nxt;
  logic [15:0] ax_r [3];
  logic [15:0] ax_nxt [3];
  logic [7:0]  burst_r [6];
  logic        bwr;
  logic [2:0]  bidx;
  logic [7:0]  bval;
  logic [7:0]  last, rxv;
  logic        scl, sda, busy, done, mack;
  logic [7:0]  addr_w;

  assign tk_take  = tk_valid && !res_full;
  assign res_push = tk_take;
  assign last     = (half_bit_ticks == 8'd0) ? 8'd0 : half_bit_ticks - 8'd1;
  assign addr_w   = {device_address, 1'b0};

  function automatic logic [7:0] byte_for(input logic [2:0] k, input logic [7:0] a,
                                          input logic [7:0] r, input logic [7:0] d);
    case (k)
      3'd0:    return a;
      3'd1:    return r;
      3'd2:    return d;
      default: return a | 8'd1;
    endcase
  endfunction

  always_comb begin
    phase_nxt = phase_r; tick_nxt = tick_r; bit_nxt = bit_r; byte_nxt = byte_r;
    shift_nxt = shift_r; cmd_nxt = cmd_r; lreg_nxt = lreg_r; ldat_nxt = ldat_r;
    nack_nxt = nack_r; rbyte_nxt = rbyte_r;
    for (int i = 0; i < 3; i++) ax_nxt[i] = ax_r[i];
    bwr = 1'b0; bidx = byte_r; bval = 8'd0;
    scl = 1'b1; sda = 1'b1; busy = 1'b0; done = 1'b0;
    if (phase_r == imr_pkg::PH_IDLE && tk.func != imr_pkg::FUNC_TICK) begin
      cmd_nxt  = tk.func;
      lreg_nxt = (tk.func == imr_pkg::FUNC_BURST) ? imr_pkg::BURST_START_REG : tk.reg_sel;
      ldat_nxt = tk.wr_byte;
      nack_nxt = 1'b0; byte_nxt = 3'd0; bit_nxt = 4'd0; tick_nxt = 8'd0;
      ph = imr_pkg::PH_START_A;
    end else begin
      ph = phase_r;
    end
    phase_nxt = ph;
    mack = !(cmd_nxt == imr_pkg::FUNC_BURST && byte_nxt < 3'd5);
    rxv  = {shift_nxt[6:0], tk.sda_in};
    if (ph != imr_pkg::PH_IDLE) begin
      busy = 1'b1;
      case (ph)
        imr_pkg::PH_START_B:  begin scl = 1'b1; sda = 1'b0; end
        imr_pkg::PH_TX_LO:    begin scl = 1'b0; sda = shift_nxt[7]; end
        imr_pkg::PH_TX_HI:    begin scl = 1'b1; sda = shift_nxt[7]; end
        imr_pkg::PH_ACKIN_LO, imr_pkg::PH_RX_LO, imr_pkg::PH_RESTART: scl = 1'b0;
        imr_pkg::PH_MACK_LO:  begin scl = 1'b0; sda = mack; end
        imr_pkg::PH_MACK_HI:  begin scl = 1'b1; sda = mack; end
        imr_pkg::PH_STOP_A:   begin scl = 1'b0; sda = 1'b0; end
        imr_pkg::PH_STOP_B:   begin scl = 1'b1; sda = 1'b0; end
        default: ;
      endcase
      if (tick_nxt >= last) begin
        tick_nxt = 8'd0;
        case (ph)
          imr_pkg::PH_START_A: phase_nxt = imr_pkg::PH_START_B;
          imr_pkg::PH_START_B: begin
            shift_nxt = byte_for(byte_nxt, addr_w, lreg_nxt, ldat_nxt);
            bit_nxt = 4'd0; phase_nxt = imr_pkg::PH_TX_LO;
          end
          imr_pkg::PH_TX_LO: phase_nxt = imr_pkg::PH_TX_HI;
          imr_pkg::PH_TX_HI: begin
            shift_nxt = {shift_nxt[6:0], 1'b0};
            if (bit_nxt >= 4'd7) begin
              bit_nxt = 4'd0; phase_nxt = imr_pkg::PH_ACKIN_LO;
            end else begin
              bit_nxt = bit_nxt + 4'd1; phase_nxt = imr_pkg::PH_TX_LO;
            end
          end
          imr_pkg::PH_ACKIN_LO: phase_nxt = imr_pkg::PH_ACKIN_HI;
          imr_pkg::PH_ACKIN_HI: begin
            if (tk.sda_in) begin
              nack_nxt = 1'b1; phase_nxt = imr_pkg::PH_STOP_A;
            end else if (cmd_nxt == imr_pkg::FUNC_WRITE) begin
              if (byte_nxt >= 3'd2) phase_nxt = imr_pkg::PH_STOP_A;
              else begin
                byte_nxt = byte_nxt + 3'd1;
                shift_nxt = byte_for(byte_nxt, addr_w, lreg_nxt, ldat_nxt);
                bit_nxt = 4'd0; phase_nxt = imr_pkg::PH_TX_LO;
              end
            end else if (byte_nxt == 3'd0) begin
              byte_nxt = 3'd1;
              shift_nxt = byte_for(3'd1, addr_w, lreg_nxt, ldat_nxt);
              bit_nxt = 4'd0; phase_nxt = imr_pkg::PH_TX_LO;
            end else if (byte_nxt == 3'd1) begin
              byte_nxt = 3'd3; phase_nxt = imr_pkg::PH_RESTART;
            end else begin
              byte_nxt = 3'd0; bit_nxt = 4'd0; shift_nxt = 8'd0;
              phase_nxt = imr_pkg::PH_RX_LO;
            end
          end
          imr_pkg::PH_RESTART: phase_nxt = imr_pkg::PH_START_A;
          imr_pkg::PH_RX_LO: phase_nxt = imr_pkg::PH_RX_HI;
          imr_pkg::PH_RX_HI: begin
            shift_nxt = rxv;
            if (bit_nxt >= 4'd7) begin
              bit_nxt = 4'd0;
              if (cmd_nxt == imr_pkg::FUNC_BURST) begin
                if (byte_nxt < 3'd6) begin bwr = 1'b1; bidx = byte_nxt; bval = rxv; end
              end else rbyte_nxt = rxv;
              phase_nxt = imr_pkg::PH_MACK_LO;
            end else begin
              bit_nxt = bit_nxt + 4'd1; phase_nxt = imr_pkg::PH_RX_LO;
            end
          end
          imr_pkg::PH_MACK_LO: phase_nxt = imr_pkg::PH_MACK_HI;
          imr_pkg::PH_MACK_HI: begin
            if (!mack) begin
              byte_nxt = byte_nxt + 3'd1; shift_nxt = 8'd0; phase_nxt = imr_pkg::PH_RX_LO;
            end else begin
              if (cmd_nxt == imr_pkg::FUNC_BURST) begin
                ax_nxt[0] = imr_pkg::convert_axis(burst_r[0], burst_r[1]);
                ax_nxt[1] = imr_pkg::convert_axis(burst_r[2], burst_r[3]);
                ax_nxt[2] = imr_pkg::convert_axis(burst_r[4], burst_r[5]);
              end
              phase_nxt = imr_pkg::PH_STOP_A;
            end
          end
          imr_pkg::PH_STOP_A: phase_nxt = imr_pkg::PH_STOP_B;
          imr_pkg::PH_STOP_B: phase_nxt = imr_pkg::PH_STOP_C;
          imr_pkg::PH_STOP_C: begin phase_nxt = imr_pkg::PH_IDLE; done = 1'b1; end
          default: phase_nxt = imr_pkg::PH_IDLE;
        endcase
      end else begin
        tick_nxt = tick_nxt + 8'd1;
      end
    end
  end

  always_comb begin
    res.scl_out = scl; res.sda_out = sda; res.busy_res = busy; res.done_res = done;
    res.nack = nack_nxt; res.read_data = rbyte_nxt;
    res.x_value = ax_nxt[0]; res.y_value = ax_nxt[1]; res.z_value = ax_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= imr_pkg::PH_IDLE;
      tick_r <= '0; bit_r <= '0; byte_r <= '0; shift_r <= '0; cmd_r <= '0;
      lreg_r <= '0; ldat_r <= '0; nack_r <= 1'b0; rbyte_r <= '0;
      for (int i = 0; i < 3; i++) ax_r[i] <= '0;
    end else if (tk_take) begin
      phase_r <= phase_nxt; tick_r <= tick_nxt; bit_r <= bit_nxt; byte_r <= byte_nxt;
      shift_r <= shift_nxt; cmd_r <= cmd_nxt; lreg_r <= lreg_nxt; ldat_r <= ldat_nxt;
      nack_r <= nack_nxt; rbyte_r <= rbyte_nxt;
      for (int i = 0; i < 3; i++) ax_r[i] <= ax_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (tk_take && bwr) burst_r[bidx] <= bval;
  end

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("phase not one-hot");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.done_res |-> res.busy_res) else $error("done without busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tk_take |=> $stable(phase_r)) else $error("phase moved without a tick");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.done_res |=> phase_r == imr_pkg::PH_IDLE) else $error("no idle after done");
endmodule
`default_nettype wire

[dv/tb_i2c_magnetometer_reader.sv]
`timescale 1ns / 100ps
module tb_i2c_magnetometer_reader;
  import imr_pkg::*;

  // clock and reset
  logic clk;
  logic rst_n;

  // input channel
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_func;
  logic [7:0]  in_reg_sel;
  logic [7:0]  in_wr_byte;
  logic        in_sda_in;

  // result channel
  logic        out_empty;
  logic        out_pop;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_nack;
  logic [7:0]  out_read_data;
  logic [15:0] out_x_value;
  logic [15:0] out_y_value;
  logic [15:0] out_z_value;

  // configuration port
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2c_magnetometer_reader dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_reg_sel   (in_reg_sel),
    .in_wr_byte   (in_wr_byte),
    .in_sda_in    (in_sda_in),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_nack     (out_nack),
    .out_read_data(out_read_data),
    .out_x_value  (out_x_value),
    .out_y_value  (out_y_value),
    .out_z_value  (out_z_value),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_PASS = 260;

  // bus engine mirror: copy of the master state, advanced once per accepted tick
  phase_t      bus_phase;
  logic [7:0]  seg_ticks;
  logic [3:0]  bit_idx;
  logic [2:0]  byte_idx;
  logic [7:0]  shifter;
  logic [1:0]  active_cmd;
  logic [7:0]  burst_buf [6];
  logic [15:0] axis_val [3];
  logic        nack_seen;
  logic [7:0]  last_read;
  logic [7:0]  held_reg;
  logic [7:0]  held_data;
  logic [7:0]  half_bit;
  logic [6:0]  slave_addr;

  // results still owed by the block, oldest first
  res_t bus_results_due[$];

  int  mismatches;
  int  idle_cycles;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;
  logic [7:0] rx_pattern [6];

  function automatic logic [7:0] tx_byte(input logic [2:0] k);
    logic [7:0] a;
    a = {slave_addr, 1'b0};
    case (k)
      3'd0: tx_byte = a;
      3'd1: tx_byte = held_reg;
      3'd2: tx_byte = held_data;
      default: tx_byte = a | 8'h01;
    endcase
  endfunction

  function automatic logic [15:0] axis_from(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] raw;
    raw = {hi, lo};
    // overflow marker reads as zero
    if (raw == 16'hF000) axis_from = 16'd0;
    else axis_from = raw + 16'd2048;
  endfunction

  function automatic logic master_ack_level();
    master_ack_level = !(active_cmd == FUNC_BURST && byte_idx < 3'd5);
  endfunction

  function automatic void load_byte();
    shifter   = tx_byte(byte_idx);
    bit_idx   = 4'd0;
    bus_phase = PH_TX_LO;
  endfunction

  // end of a segment: move to the next one, 1 when the stop has finished
  function automatic logic next_segment(input logic s);
    next_segment = 1'b0;
    case (bus_phase)
      PH_START_A:  bus_phase = PH_START_B;
      PH_START_B:  load_byte();
      PH_TX_LO:    bus_phase = PH_TX_HI;
      PH_TX_HI: begin
        shifter = shifter << 1;
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) begin
          bit_idx   = 4'd0;
          bus_phase = PH_ACKIN_LO;
        end else begin
          bus_phase = PH_TX_LO;
        end
      end
      PH_ACKIN_LO: bus_phase = PH_ACKIN_HI;
      PH_ACKIN_HI: begin
        if (s) begin
          nack_seen = 1'b1;
          bus_phase = PH_STOP_A;
        end else if (active_cmd == FUNC_WRITE) begin
          if (byte_idx >= 3'd2) begin
            bus_phase = PH_STOP_A;
          end else begin
            byte_idx = byte_idx + 3'd1;
            load_byte();
          end
        end else if (byte_idx == 3'd0) begin
          byte_idx = 3'd1;
          load_byte();
        end else if (byte_idx == 3'd1) begin
          byte_idx  = 3'd3;
          bus_phase = PH_RESTART;
        end else begin
          byte_idx  = 3'd0;
          bit_idx   = 4'd0;
          shifter   = 8'd0;
          bus_phase = PH_RX_LO;
        end
      end
      PH_RESTART:  bus_phase = PH_START_A;
      PH_RX_LO:    bus_phase = PH_RX_HI;
      PH_RX_HI: begin
        shifter = {shifter[6:0], s};
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) begin
          bit_idx = 4'd0;
          if (active_cmd == FUNC_BURST) begin
            if (byte_idx < 3'd6) burst_buf[byte_idx] = shifter;
          end else begin
            last_read = shifter;
          end
          bus_phase = PH_MACK_LO;
        end else begin
          bus_phase = PH_RX_LO;
        end
      end
      PH_MACK_LO:  bus_phase = PH_MACK_HI;
      PH_MACK_HI: begin
        if (active_cmd == FUNC_BURST && byte_idx < 3'd5) begin
          byte_idx  = byte_idx + 3'd1;
          shifter   = 8'd0;
          bus_phase = PH_RX_LO;
        end else begin
          if (active_cmd == FUNC_BURST) begin
            axis_val[0] = axis_from(burst_buf[0], burst_buf[1]);
            axis_val[1] = axis_from(burst_buf[2], burst_buf[3]);
            axis_val[2] = axis_from(burst_buf[4], burst_buf[5]);
          end
          bus_phase = PH_STOP_A;
        end
      end
      PH_STOP_A:   bus_phase = PH_STOP_B;
      PH_STOP_B:   bus_phase = PH_STOP_C;
      PH_STOP_C: begin
        bus_phase    = PH_IDLE;
        next_segment = 1'b1;
      end
      default:     bus_phase = PH_IDLE;
    endcase
  endfunction

  // one timing tick of the master
  function automatic res_t bus_tick(input logic [1:0] f, input logic [7:0] r,
                                    input logic [7:0] d, input logic s);
    res_t o;
    logic [7:0] last_tick;
    o = '0;
    o.scl_out = 1'b1;
    o.sda_out = 1'b1;
    if (bus_phase == PH_IDLE && f != FUNC_TICK) begin
      active_cmd = f;
      held_reg   = (f == FUNC_BURST) ? BURST_START_REG : r;
      held_data  = d;
      nack_seen  = 1'b0;
      byte_idx   = 3'd0;
      bit_idx    = 4'd0;
      seg_ticks  = 8'd0;
      bus_phase  = PH_START_A;
    end
    if (bus_phase != PH_IDLE) begin
      // zero half-bit count acts as one
      last_tick  = (half_bit == 8'd0) ? 8'd0 : half_bit - 8'd1;
      o.busy_res = 1'b1;
      case (bus_phase)
        PH_START_A:  begin o.scl_out = 1'b1; o.sda_out = 1'b1; end
        PH_START_B:  begin o.scl_out = 1'b1; o.sda_out = 1'b0; end
        PH_TX_LO:    begin o.scl_out = 1'b0; o.sda_out = shifter[7]; end
        PH_TX_HI:    begin o.scl_out = 1'b1; o.sda_out = shifter[7]; end
        PH_ACKIN_LO: begin o.scl_out = 1'b0; o.sda_out = 1'b1; end
        PH_ACKIN_HI: begin o.scl_out = 1'b1; o.sda_out = 1'b1; end
        PH_RX_LO:    begin o.scl_out = 1'b0; o.sda_out = 1'b1; end
        PH_RX_HI:    begin o.scl_out = 1'b1; o.sda_out = 1'b1; end
        PH_MACK_LO:  begin o.scl_out = 1'b0; o.sda_out = master_ack_level(); end
        PH_MACK_HI:  begin o.scl_out = 1'b1; o.sda_out = master_ack_level(); end
        PH_RESTART:  begin o.scl_out = 1'b0; o.sda_out = 1'b1; end
        PH_STOP_A:   begin o.scl_out = 1'b0; o.sda_out = 1'b0; end
        PH_STOP_B:   begin o.scl_out = 1'b1; o.sda_out = 1'b0; end
        default:     begin o.scl_out = 1'b1; o.sda_out = 1'b1; end
      endcase
      // a lowered timing register ends the segment right away
      if (seg_ticks >= last_tick) begin
        seg_ticks  = 8'd0;
        o.done_res = next_segment(s);
      end else begin
        seg_ticks = seg_ticks + 8'd1;
      end
    end
    o.nack      = nack_seen;
    o.read_data = last_read;
    o.x_value   = axis_val[0];
    o.y_value   = axis_val[1];
    o.z_value   = axis_val[2];
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one tick and wait for its transfer, with random gaps in front
  task automatic send_tick(input logic [1:0] f, input logic [7:0] r, input logic [7:0] d,
                           input logic s, input bit typed, input res_t typed_res);
    res_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_func    <= f;
    in_reg_sel <= r;
    in_wr_byte <= d;
    in_sda_in  <= s;
    @(posedge clk);
    while (in_full) @(posedge clk);
    p = bus_tick(f, r, d, s);
    bus_results_due.push_back(typed ? typed_res : p);
  endtask

  // stop offering and let every owed result come out
  task automatic drain();
    in_push <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
  endtask

  // apb write: setup, then access; lands when penable and pready are high
  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == CFG_HALF_BIT) half_bit = val[7:0];
    else if (idx == CFG_DEV_ADDR) slave_addr = val[6:0];
  endtask

  // random tick, mostly shaped so that transactions get acked deep into the read
  task automatic random_tick();
    logic [1:0] f;
    logic       s;
    int         k;
    f = 2'($urandom_range(3));
    if (bus_phase == PH_IDLE) begin
      if ($urandom_range(99) < 75) f = 2'($urandom_range(3, 1));
      for (k = 0; k < 6; k++) begin
        case ($urandom_range(5))
          0: rx_pattern[k] = (k % 2 == 0) ? 8'hF0 : 8'h00;
          1: rx_pattern[k] = 8'hFF;
          2: rx_pattern[k] = (k % 2 == 0) ? 8'h7F : 8'hFF;
          default: rx_pattern[k] = 8'($urandom_range(255));
        endcase
      end
    end
    case (bus_phase)
      PH_ACKIN_LO, PH_ACKIN_HI: s = ($urandom_range(99) < 4);
      PH_RX_LO, PH_RX_HI: s = rx_pattern[byte_idx][3'd7 - bit_idx[2:0]];
      default: s = 1'($urandom_range(1));
    endcase
    send_tick(f, 8'($urandom_range(255)), 8'($urandom_range(255)), s, 1'b0, '0);
  endtask

  // directed table: one row per run of identical ticks
  typedef struct {
    logic [1:0] func;
    logic [7:0] reg_sel;
    logic [7:0] wr_byte;
    logic       sda;
    int         count;
    bit         typed;
    res_t       res;
  } tick_row_t;

  tick_row_t script [7];

  initial begin
    int i, j, pass_no;
    res_t idle_res, done_res_v, nack_idle;

    in_push     = 1'b0;
    in_func     = FUNC_TICK;
    in_reg_sel  = 8'd0;
    in_wr_byte  = 8'd0;
    in_sda_in   = 1'b1;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'd0;
    cfg_pwdata  = 32'd0;
    tx_idle_pct = 25;
    rx_idle_pct = 62;
    hold_req    = 1'b0;
    mismatches  = 0;

    // reset state of the mirror
    bus_phase  = PH_IDLE;
    seg_ticks  = 8'd0;
    bit_idx    = 4'd0;
    byte_idx   = 3'd0;
    shifter    = 8'd0;
    active_cmd = FUNC_TICK;
    for (i = 0; i < 6; i++) burst_buf[i] = 8'd0;
    for (i = 0; i < 3; i++) axis_val[i] = 16'd0;
    nack_seen  = 1'b0;
    last_read  = 8'd0;
    held_reg   = 8'd0;
    held_data  = 8'd0;
    half_bit   = 8'd7;
    slave_addr = 7'd30;

    idle_res   = '0;
    idle_res.scl_out = 1'b1;
    idle_res.sda_out = 1'b1;
    done_res_v = idle_res;
    done_res_v.busy_res = 1'b1;
    done_res_v.done_res = 1'b1;
    done_res_v.nack     = 1'b1;
    nack_idle  = idle_res;
    nack_idle.nack = 1'b1;

    // one-tick segments: a write whose address is never acked runs 23 ticks
    script[0] = '{FUNC_TICK,  8'h00, 8'h00, 1'b1, 1,  1'b1, idle_res};
    script[1] = '{FUNC_WRITE, 8'hFF, 8'h00, 1'b1, 1,  1'b0, '0};
    script[2] = '{FUNC_BURST, 8'h00, 8'hFF, 1'b1, 21, 1'b0, '0};  // ignored while busy
    script[3] = '{FUNC_READ,  8'hFF, 8'hFF, 1'b1, 1,  1'b1, done_res_v};
    script[4] = '{FUNC_TICK,  8'hFF, 8'hFF, 1'b0, 1,  1'b1, nack_idle};
    script[5] = '{FUNC_READ,  8'h00, 8'h00, 1'b0, 1,  1'b0, '0};  // new command clears nack
    script[6] = '{FUNC_TICK,  8'h00, 8'h00, 1'b0, 1,  1'b0, '0};

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_HALF_BIT, 32'd1);
    for (i = 0; i < 7; i++)
      for (j = 0; j < script[i].count; j++)
        send_tick(script[i].func, script[i].reg_sel, script[i].wr_byte, script[i].sda,
                  script[i].typed, script[i].res);

    // random passes, each under its own register setting
    for (pass_no = 0; pass_no < 6; pass_no++) begin
      drain();
      case (pass_no)
        0: begin write_reg(CFG_HALF_BIT, 32'd1); write_reg(CFG_DEV_ADDR, 32'd0); end
        1: begin write_reg(CFG_HALF_BIT, 32'd2); write_reg(CFG_DEV_ADDR, 32'd127); end
        // zero half bit, and address bits above bit six dropped
        2: begin write_reg(CFG_HALF_BIT, 32'd0); write_reg(CFG_DEV_ADDR, 32'hFFFF_FFD5); end
        3: begin write_reg(CFG_HALF_BIT, 32'd255); write_reg(CFG_DEV_ADDR, 32'd30); end
        // lowered mid-segment: previous pass left a long segment running
        4: write_reg(CFG_HALF_BIT, 32'hFFFF_FF01);
        default: begin write_reg(CFG_HALF_BIT, 32'd3); write_reg(CFG_DEV_ADDR, 32'd85); end
      endcase
      if (pass_no == 2) begin
        tx_idle_pct = 62;
        rx_idle_pct = 25;
      end else if (pass_no == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (i = 0; i < ITEMS_PER_PASS; i++) begin
        // long receiver stall while the sender keeps offering
        if (pass_no == 1 && i == 40) hold_req = 1'b1;
        random_tick();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: checks each result transfer against the oldest owed result
  initial begin
    int   hold_left;
    res_t want;
    res_t got;
    hold_left = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.scl_out   = out_scl_out;
        got.sda_out   = out_sda_out;
        got.busy_res  = out_busy_res;
        got.done_res  = out_done_res;
        got.nack      = out_nack;
        got.read_data = out_read_data;
        got.x_value   = out_x_value;
        got.y_value   = out_y_value;
        got.z_value   = out_z_value;
        if (bus_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %p", got);
        end else begin
          want = bus_results_due.pop_front();
          if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
              got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
              got.nack !== want.nack || got.read_data !== want.read_data ||
              got.x_value !== want.x_value || got.y_value !== want.y_value ||
              got.z_value !== want.z_value) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: cycles with no transfer on either channel and no cfg_ access
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
